FILE: hw/rtl/ter_pkg.sv
// ----------------------------------------------------------------------------
// ter_pkg
// Shared types and constants of the triangle edge rasterizer.
// ----------------------------------------------------------------------------
`default_nettype none

package ter_pkg;

  localparam int CFG_ADDR_W   = 5;
  localparam int CFG_DATA_W   = 32;
  localparam int FRAME_DIM_W  = 13;
  localparam int PITCH_W      = 17;
  localparam int ADDR_W       = 32;
  localparam int DEPTH_W      = 6;
  localparam int COLOR_W      = 32;

  localparam logic [FRAME_DIM_W-1:0] FRAME_WIDTH_RST  = 13'd640;
  localparam logic [FRAME_DIM_W-1:0] FRAME_HEIGHT_RST = 13'd480;
  localparam logic [PITCH_W-1:0]     ROW_PITCH_RST    = 17'd2560;
  localparam logic [ADDR_W-1:0]      FRAME_BASE_RST   = 32'd0;
  localparam logic [DEPTH_W-1:0]     BPP_RST          = 6'd32;
  localparam logic [DEPTH_W-1:0]     FULL_DEPTH       = 6'd32;

  typedef enum logic [2:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_ROW_PITCH    = 3'd2,
    REG_FRAME_BASE   = 3'd3,
    REG_BPP          = 3'd4
  } reg_idx_t;

  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_TICK = 1'b1
  } kind_t;

  typedef struct packed {
    logic [FRAME_DIM_W-1:0] frame_width;
    logic [FRAME_DIM_W-1:0] frame_height;
    logic [PITCH_W-1:0]     row_pitch;
    logic [ADDR_W-1:0]      frame_base;
    logic [DEPTH_W-1:0]     bits_per_pixel;
  } ter_cfg_t;

  typedef struct packed {
    kind_t kind;
    logic  empty;
    logic  rejected;
  } ter_ctl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/ter_cfg_regs.sv
// ----------------------------------------------------------------------------
// ter_cfg_regs
// APB-style register file holding the framebuffer description.
// ----------------------------------------------------------------------------
`default_nettype none

module ter_cfg_regs
  import ter_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output ter_cfg_t              cfg
);

  ter_cfg_t cfg_r;
  logic     wr_en;
  reg_idx_t idx;

  assign wr_en = psel & penable & pwrite;
  assign idx   = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
  assign cfg   = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_width    <= FRAME_WIDTH_RST;
      cfg_r.frame_height   <= FRAME_HEIGHT_RST;
      cfg_r.row_pitch      <= ROW_PITCH_RST;
      cfg_r.frame_base     <= FRAME_BASE_RST;
      cfg_r.bits_per_pixel <= BPP_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_FRAME_WIDTH:  cfg_r.frame_width    <= pwdata[FRAME_DIM_W-1:0];
        REG_FRAME_HEIGHT: cfg_r.frame_height   <= pwdata[FRAME_DIM_W-1:0];
        REG_ROW_PITCH:    cfg_r.row_pitch      <= pwdata[PITCH_W-1:0];
        REG_FRAME_BASE:   cfg_r.frame_base     <= pwdata[ADDR_W-1:0];
        REG_BPP:          cfg_r.bits_per_pixel <= pwdata[DEPTH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_FRAME_WIDTH:  prdata = CFG_DATA_W'(cfg_r.frame_width);
      REG_FRAME_HEIGHT: prdata = CFG_DATA_W'(cfg_r.frame_height);
      REG_ROW_PITCH:    prdata = CFG_DATA_W'(cfg_r.row_pitch);
      REG_FRAME_BASE:   prdata = CFG_DATA_W'(cfg_r.frame_base);
      REG_BPP:          prdata = CFG_DATA_W'(cfg_r.bits_per_pixel);
      default:          prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/ter_setup.sv
// ----------------------------------------------------------------------------
// ter_setup
// Two-stage triangle setup: clamped bounding box and edge coefficients,
// then the products that seed the edge functions at the box corner.
// ----------------------------------------------------------------------------
`default_nettype none

module ter_setup
  import ter_pkg::*;
#(
  parameter int MAX_DIM    = 4096,
  parameter int COORD_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 en1,
  input  logic                                 en2,
  input  ter_cfg_t                             cfg,
  input  kind_t                                in_kind,
  input  logic signed [COORD_BITS-1:0]         in_vx [3],
  input  logic signed [COORD_BITS-1:0]         in_vy [3],
  input  logic [COLOR_W-1:0]                   in_color,
  output ter_ctl_t                             s2_ctl,
  output logic [$clog2(MAX_DIM)-1:0]           s2_lx,
  output logic [$clog2(MAX_DIM)-1:0]           s2_ly,
  output logic [$clog2(MAX_DIM)-1:0]           s2_hx,
  output logic [$clog2(MAX_DIM)-1:0]           s2_hy,
  output logic signed [2*((COORD_BITS > $clog2(MAX_DIM)+1 ? COORD_BITS
                          : $clog2(MAX_DIM)+1)+1)-1:0] s2_pa [3],
  output logic signed [2*((COORD_BITS > $clog2(MAX_DIM)+1 ? COORD_BITS
                          : $clog2(MAX_DIM)+1)+1)-1:0] s2_pb [3],
  output logic signed [(COORD_BITS > $clog2(MAX_DIM)+1 ? COORD_BITS
                        : $clog2(MAX_DIM)+1):0]        s2_ca [3],
  output logic signed [(COORD_BITS > $clog2(MAX_DIM)+1 ? COORD_BITS
                        : $clog2(MAX_DIM)+1):0]        s2_cb [3],
  output logic [COLOR_W-1:0]                   s2_color
);

  localparam int PosW  = $clog2(MAX_DIM);
  localparam int RectW = $clog2(MAX_DIM + 1);
  localparam int DW    = (COORD_BITS > PosW + 1 ? COORD_BITS : PosW + 1) + 1;
  localparam int PW    = 2 * DW;
  localparam int DimW  = FRAME_DIM_W > RectW ? FRAME_DIM_W : RectW;
  localparam int SW    = (COORD_BITS > DimW + 1 ? COORD_BITS : DimW + 1) + 1;
  localparam int A_IDX [3] = '{1, 2, 0};
  localparam int B_IDX [3] = '{2, 0, 1};

  // stage 1 combinational
  logic [DimW-1:0]          w_cl, h_cl, fw_ext, fh_ext;
  logic signed [SW-1:0]     w_m1, h_m1;
  logic signed [COORD_BITS-1:0] xmin, xmax, ymin, ymax;
  logic signed [SW-1:0]     lxc, lyc, hxc, hyc, lxs, lys, hxs, hys;
  logic signed [DW-1:0]     lxn, lyn;
  ter_ctl_t                 ctl1;

  // stage 1 registers
  ter_ctl_t                 ctl1_r;
  logic [PosW-1:0]          lx1_r, ly1_r, hx1_r, hy1_r;
  logic signed [DW-1:0]     dx1_r [3];
  logic signed [DW-1:0]     dy1_r [3];
  logic signed [DW-1:0]     ca1_r [3];
  logic signed [DW-1:0]     cb1_r [3];
  logic [COLOR_W-1:0]       color1_r;

  // stage 2 registers
  ter_ctl_t                 ctl2_r;
  logic [PosW-1:0]          lx2_r, ly2_r, hx2_r, hy2_r;
  logic signed [PW-1:0]     pa2_r [3];
  logic signed [PW-1:0]     pb2_r [3];
  logic signed [DW-1:0]     ca2_r [3];
  logic signed [DW-1:0]     cb2_r [3];
  logic [COLOR_W-1:0]       color2_r;

  always_comb begin
    fw_ext = DimW'(cfg.frame_width);
    fh_ext = DimW'(cfg.frame_height);
    w_cl   = (fw_ext > DimW'(MAX_DIM)) ? DimW'(MAX_DIM) : fw_ext;
    h_cl   = (fh_ext > DimW'(MAX_DIM)) ? DimW'(MAX_DIM) : fh_ext;
    w_m1   = $signed(SW'(w_cl)) - SW'(1);
    h_m1   = $signed(SW'(h_cl)) - SW'(1);

    xmin = (in_vx[0] < in_vx[1]) ? in_vx[0] : in_vx[1];
    xmin = (xmin < in_vx[2]) ? xmin : in_vx[2];
    xmax = (in_vx[0] > in_vx[1]) ? in_vx[0] : in_vx[1];
    xmax = (xmax > in_vx[2]) ? xmax : in_vx[2];
    ymin = (in_vy[0] < in_vy[1]) ? in_vy[0] : in_vy[1];
    ymin = (ymin < in_vy[2]) ? ymin : in_vy[2];
    ymax = (in_vy[0] > in_vy[1]) ? in_vy[0] : in_vy[1];
    ymax = (ymax > in_vy[2]) ? ymax : in_vy[2];

    lxs = SW'(xmin);
    lys = SW'(ymin);
    hxs = SW'(xmax);
    hys = SW'(ymax);
    lxc = lxs[SW-1] ? '0 : lxs;
    lyc = lys[SW-1] ? '0 : lys;
    hxc = (hxs > w_m1) ? w_m1 : hxs;
    hyc = (hys > h_m1) ? h_m1 : hys;

    lxn = DW'($signed({1'b0, lxc[PosW-1:0]}));
    lyn = DW'($signed({1'b0, lyc[PosW-1:0]}));

    ctl1.kind     = in_kind;
    ctl1.empty    = (lxc > hxc) | (lyc > hyc);
    ctl1.rejected = (cfg.bits_per_pixel != FULL_DEPTH) | (cfg.frame_base == '0);
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      ctl1_r   <= ctl1;
      lx1_r    <= lxc[PosW-1:0];
      ly1_r    <= lyc[PosW-1:0];
      hx1_r    <= hxc[PosW-1:0];
      hy1_r    <= hyc[PosW-1:0];
      color1_r <= in_color;
      for (int i = 0; i < 3; i++) begin
        dx1_r[i] <= lxn - DW'(in_vx[A_IDX[i]]);
        dy1_r[i] <= lyn - DW'(in_vy[A_IDX[i]]);
        ca1_r[i] <= DW'(in_vy[B_IDX[i]]) - DW'(in_vy[A_IDX[i]]);
        cb1_r[i] <= DW'(in_vx[B_IDX[i]]) - DW'(in_vx[A_IDX[i]]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      ctl2_r   <= ctl1_r;
      lx2_r    <= lx1_r;
      ly2_r    <= ly1_r;
      hx2_r    <= hx1_r;
      hy2_r    <= hy1_r;
      color2_r <= color1_r;
      for (int i = 0; i < 3; i++) begin
        pa2_r[i] <= dx1_r[i] * ca1_r[i];
        pb2_r[i] <= dy1_r[i] * cb1_r[i];
        ca2_r[i] <= ca1_r[i];
        cb2_r[i] <= cb1_r[i];
      end
    end
  end

  assign s2_ctl   = ctl2_r;
  assign s2_lx    = lx2_r;
  assign s2_ly    = ly2_r;
  assign s2_hx    = hx2_r;
  assign s2_hy    = hy2_r;
  assign s2_pa    = pa2_r;
  assign s2_pb    = pb2_r;
  assign s2_ca    = ca2_r;
  assign s2_cb    = cb2_r;
  assign s2_color = color2_r;

endmodule

`default_nettype wire

FILE: hw/rtl/triangle_edge_rasterizer_unit.sv
// ----------------------------------------------------------------------------
// triangle_edge_rasterizer_unit
// Flat-shaded triangle rasterizer walking a clamped bounding box.
// ----------------------------------------------------------------------------
// Input stream: tuser selects the word kind (load or tick). A load word
// carries three signed vertices and a flat color and is answered with the
// dirty rectangle; a tick word visits the next pixel of the box in raster
// order and is answered with its inside flag, byte address and color.
// tlast on the output marks the final pixel of the box, or an answer after
// which no traversal runs.
// Every input word gives exactly one output word. Four register stages:
// input register, box setup, edge seed products, result register.
// Throughput is one word per clock while the output is not stalled: edge
// functions advance by one add per pixel, and the per-pixel address uses
// one row-pitch multiply. When the output is stalled, the pipeline
// collapses its bubbles and then holds; in_tready drops only when all
// four stages are full.
// Reset clears the stage valid bits and the traversal and loads the
// register defaults (640 x 480, pitch 2560, base 0, depth 32).
// Registers sit at byte addresses 0,4,8,12,16 of the APB-style port.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_edge_rasterizer_unit
  import ter_pkg::*;
#(
  parameter int MAX_DIM    = 4096,
  parameter int COORD_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // vert0_x, vert0_y, vert1_x, vert1_y, vert2_x, vert2_y, fill_color
  input  logic [((6*COORD_BITS+COLOR_W+7)/8)*8-1:0] in_tdata,
  // req_type
  input  logic [0:0]            in_tuser,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // pos_x, pos_y, rect_w, rect_h, pixel_write, pixel_addr, pixel_color,
  // rejected
  output logic [((2*$clog2(MAX_DIM)+2*$clog2(MAX_DIM+1)+2*32+2+7)/8)*8-1:0]
                                out_tdata,
  // result_kind
  output logic [0:0]            out_tuser,
  output logic                  out_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam int PosW     = $clog2(MAX_DIM);
  localparam int RectW    = $clog2(MAX_DIM + 1);
  localparam int DW       = (COORD_BITS > PosW + 1 ? COORD_BITS : PosW + 1) + 1;
  localparam int PW       = 2 * DW;
  localparam int EW       = PW + 1;
  localparam int OutDataW = ((2*PosW + 2*RectW + 2*32 + 2 + 7) / 8) * 8;
  localparam int RowW     = PosW + PITCH_W;

  ter_cfg_t cfg;

  // pipeline valids and advance
  logic p0_v_r, p1_v_r, p2_v_r, out_v_r;
  logic adv0, adv1, adv2, adv_out, fire_c;

  // input register
  kind_t                        p0_kind_r;
  logic signed [COORD_BITS-1:0] p0_vx_r [3];
  logic signed [COORD_BITS-1:0] p0_vy_r [3];
  logic [COLOR_W-1:0]           p0_color_r;

  // setup outputs
  ter_ctl_t             s2_ctl;
  logic [PosW-1:0]      s2_lx, s2_ly, s2_hx, s2_hy;
  logic signed [PW-1:0] s2_pa [3];
  logic signed [PW-1:0] s2_pb [3];
  logic signed [DW-1:0] s2_ca [3];
  logic signed [DW-1:0] s2_cb [3];
  logic [COLOR_W-1:0]   s2_color;

  // traversal state
  logic                 act_r, act_nxt;
  logic [PosW-1:0]      lx_r, ly_r, hx_r, hy_r, cx_r, cy_r;
  logic [PosW-1:0]      lx_nxt, ly_nxt, hx_nxt, hy_nxt, cx_nxt, cy_nxt;
  logic [COLOR_W-1:0]   color_r, color_nxt;
  logic signed [EW-1:0] e_r [3];
  logic signed [EW-1:0] e_nxt [3];
  logic signed [EW-1:0] erow_r [3];
  logic signed [EW-1:0] erow_nxt [3];
  logic signed [DW-1:0] ca_r [3];
  logic signed [DW-1:0] ca_nxt [3];
  logic signed [DW-1:0] cb_r [3];
  logic signed [DW-1:0] cb_nxt [3];

  // result register
  kind_t              o_kind_r, o_kind_nxt;
  logic [PosW-1:0]    o_px_r, o_px_nxt, o_py_r, o_py_nxt;
  logic [RectW-1:0]   o_rw_r, o_rw_nxt, o_rh_r, o_rh_nxt;
  logic               o_pw_r, o_pw_nxt, o_last_r, o_last_nxt, o_rej_r, o_rej_nxt;
  logic [ADDR_W-1:0]  o_addr_r, o_addr_nxt;
  logic [COLOR_W-1:0] o_color_r, o_color_nxt;

  logic [RowW-1:0]    row_off;
  logic               all_pos, all_neg;

  ter_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  assign cfg_pready = 1'b1;

  assign adv_out   = ~out_v_r | out_tready;
  assign adv2      = ~p2_v_r | adv_out;
  assign adv1      = ~p1_v_r | adv2;
  assign adv0      = ~p0_v_r | adv1;
  assign in_tready = adv0;
  assign fire_c    = p2_v_r & adv_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0_v_r  <= 1'b0;
      p1_v_r  <= 1'b0;
      p2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (adv0)    p0_v_r  <= in_tvalid;
      if (adv1)    p1_v_r  <= p0_v_r;
      if (adv2)    p2_v_r  <= p1_v_r;
      if (adv_out) out_v_r <= p2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv0 && in_tvalid) begin
      p0_kind_r  <= kind_t'(in_tuser[0]);
      p0_color_r <= in_tdata[6*COORD_BITS +: COLOR_W];
      for (int k = 0; k < 3; k++) begin
        p0_vx_r[k] <= in_tdata[2*k*COORD_BITS +: COORD_BITS];
        p0_vy_r[k] <= in_tdata[(2*k+1)*COORD_BITS +: COORD_BITS];
      end
    end
  end

  ter_setup #(
    .MAX_DIM    (MAX_DIM),
    .COORD_BITS (COORD_BITS)
  ) u_setup (
    .clk      (clk),
    .en1      (adv1 & p0_v_r),
    .en2      (adv2 & p1_v_r),
    .cfg      (cfg),
    .in_kind  (p0_kind_r),
    .in_vx    (p0_vx_r),
    .in_vy    (p0_vy_r),
    .in_color (p0_color_r),
    .s2_ctl   (s2_ctl),
    .s2_lx    (s2_lx),
    .s2_ly    (s2_ly),
    .s2_hx    (s2_hx),
    .s2_hy    (s2_hy),
    .s2_pa    (s2_pa),
    .s2_pb    (s2_pb),
    .s2_ca    (s2_ca),
    .s2_cb    (s2_cb),
    .s2_color (s2_color)
  );

  assign row_off = cy_r * cfg.row_pitch;

  always_comb begin
    act_nxt   = act_r;
    lx_nxt    = lx_r;
    ly_nxt    = ly_r;
    hx_nxt    = hx_r;
    hy_nxt    = hy_r;
    cx_nxt    = cx_r;
    cy_nxt    = cy_r;
    color_nxt = color_r;
    e_nxt     = e_r;
    erow_nxt  = erow_r;
    ca_nxt    = ca_r;
    cb_nxt    = cb_r;

    o_kind_nxt  = s2_ctl.kind;
    o_px_nxt    = '0;
    o_py_nxt    = '0;
    o_rw_nxt    = '0;
    o_rh_nxt    = '0;
    o_pw_nxt    = 1'b0;
    o_addr_nxt  = '0;
    o_color_nxt = '0;
    o_last_nxt  = 1'b1;
    o_rej_nxt   = 1'b0;

    all_pos = 1'b1;
    all_neg = 1'b1;
    for (int i = 0; i < 3; i++) begin
      all_pos = all_pos & ~e_r[i][EW-1];
      all_neg = all_neg & (e_r[i][EW-1] | (e_r[i] == '0));
    end

    if (s2_ctl.kind == KIND_LOAD) begin
      color_nxt = s2_color;
      act_nxt   = ~s2_ctl.empty & ~s2_ctl.rejected;
      o_rej_nxt = s2_ctl.rejected;
      if (!s2_ctl.empty) begin
        lx_nxt   = s2_lx;
        ly_nxt   = s2_ly;
        hx_nxt   = s2_hx;
        hy_nxt   = s2_hy;
        cx_nxt   = s2_lx;
        cy_nxt   = s2_ly;
        o_px_nxt = s2_lx;
        o_py_nxt = s2_ly;
        o_rw_nxt = RectW'(s2_hx) - RectW'(s2_lx) + RectW'(1);
        o_rh_nxt = RectW'(s2_hy) - RectW'(s2_ly) + RectW'(1);
        for (int i = 0; i < 3; i++) begin
          e_nxt[i]    = EW'(s2_pa[i]) - EW'(s2_pb[i]);
          erow_nxt[i] = EW'(s2_pa[i]) - EW'(s2_pb[i]);
          ca_nxt[i]   = s2_ca[i];
          cb_nxt[i]   = s2_cb[i];
        end
      end
      o_last_nxt = ~act_nxt;
    end else if (act_r) begin
      o_px_nxt    = cx_r;
      o_py_nxt    = cy_r;
      o_pw_nxt    = all_pos | all_neg;
      o_addr_nxt  = cfg.frame_base + ADDR_W'(row_off) + ADDR_W'({cx_r, 2'b00});
      o_color_nxt = color_r;
      o_last_nxt  = 1'b0;
      if (cx_r >= hx_r) begin
        if (cy_r >= hy_r) begin
          act_nxt    = 1'b0;
          o_last_nxt = 1'b1;
        end else begin
          cx_nxt = lx_r;
          cy_nxt = cy_r + PosW'(1);
          for (int i = 0; i < 3; i++) begin
            erow_nxt[i] = erow_r[i] - EW'(cb_r[i]);
            e_nxt[i]    = erow_r[i] - EW'(cb_r[i]);
          end
        end
      end else begin
        cx_nxt = cx_r + PosW'(1);
        for (int i = 0; i < 3; i++) begin
          e_nxt[i] = e_r[i] + EW'(ca_r[i]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
    end else if (fire_c) begin
      act_r <= act_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire_c) begin
      lx_r      <= lx_nxt;
      ly_r      <= ly_nxt;
      hx_r      <= hx_nxt;
      hy_r      <= hy_nxt;
      cx_r      <= cx_nxt;
      cy_r      <= cy_nxt;
      color_r   <= color_nxt;
      e_r       <= e_nxt;
      erow_r    <= erow_nxt;
      ca_r      <= ca_nxt;
      cb_r      <= cb_nxt;
      o_kind_r  <= o_kind_nxt;
      o_px_r    <= o_px_nxt;
      o_py_r    <= o_py_nxt;
      o_rw_r    <= o_rw_nxt;
      o_rh_r    <= o_rh_nxt;
      o_pw_r    <= o_pw_nxt;
      o_addr_r  <= o_addr_nxt;
      o_color_r <= o_color_nxt;
      o_last_r  <= o_last_nxt;
      o_rej_r   <= o_rej_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = o_kind_r;
  assign out_tlast  = o_last_r;
  assign out_tdata  = OutDataW'({o_rej_r, o_color_r, o_addr_r, o_pw_r,
                                 o_rh_r, o_rw_r, o_py_r, o_px_r});

`ifndef SYNTHESIS
  a_pos_in_box: assert property (@(posedge clk) disable iff (!rst_n)
    act_r |-> (cx_r >= lx_r) && (cx_r <= hx_r) && (cy_r >= ly_r) && (cy_r <= hy_r))
    else $error("traversal position left the box");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> p0_v_r && p1_v_r && p2_v_r && out_v_r && !out_tready)
    else $error("input stalled with room in the pipeline");

  a_stage_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    fire_c |=> out_v_r)
    else $error("finished word did not reach the result register");

  a_rej_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && (o_kind_r == KIND_LOAD) && o_rej_r |-> o_last_r && !act_r)
    else $error("rejected load started a traversal");

  a_idle_tick: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && (o_kind_r == KIND_TICK) && !o_last_r |-> act_r)
    else $error("pixel visit continues without an active traversal");
`endif

endmodule

`default_nettype wire
